### hdl/utf7d_pkg.sv
// Shared types, constants and the base64 symbol table for the UTF-7 byte decoder.
`default_nettype none

package utf7d_pkg;

  // Byte that closes a base64 run.
  localparam logic [7:0] DASH_BYTE = 8'h2D;
  // Escape byte after reset (ASCII plus).
  localparam logic [7:0] ESCAPE_RESET = 8'h2B;

  // Status codes carried with each result beat.
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_ILLEGAL = 1'b1;

  // One decoded result as it leaves the decode core.
  typedef struct packed {
    logic        emit;
    logic [15:0] code_unit;
    logic        status;
  } utf7d_result_t;

  // Symbol lookup: bit 6 flags a member of the alphabet, bits 5:0 hold its value.
  function automatic logic [6:0] symbol_value(input logic [7:0] b);
    logic [7:0] d;
    logic [6:0] r;
    d = 8'h00;
    r = 7'h00;
    if (b inside {[8'h41:8'h5A]}) begin
      d = b - 8'h41;
      r = {1'b1, d[5:0]};
    end else if (b inside {[8'h61:8'h7A]}) begin
      d = b - 8'h61 + 8'd26;
      r = {1'b1, d[5:0]};
    end else if (b inside {[8'h30:8'h39]}) begin
      d = b - 8'h30 + 8'd52;
      r = {1'b1, d[5:0]};
    end else if (b == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (b == 8'h2F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/utf7d_in_stage.sv
// Input register that holds one byte beat until the decode core takes it.
`default_nettype none

module utf7d_in_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       take,
  output logic            held_valid,
  output logic [7:0]      held_byte
);

  // The register may refill in the same cycle that the core takes its byte.
  assign in_ready = !held_valid || take;

  // Valid flag of the held byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= in_byte;
    end
  end

endmodule

`default_nettype wire

### hdl/utf7d_core.sv
// Decode core: mode and accumulator state, escape register and next-result logic.
`default_nettype none

module utf7d_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [7:0] cfg_data,
  input  wire logic       take,
  input  wire logic [7:0] byte_in,
  output utf7d_pkg::utf7d_result_t result
);
  import utf7d_pkg::*;

  logic [7:0]  escape_byte;
  logic        in_base64;
  logic        fresh;
  logic [15:0] acc;
  logic [2:0]  phase;

  logic        in_base64_next;
  logic        fresh_next;
  logic [15:0] acc_next;
  logic [2:0]  phase_next;

  logic [6:0]  sym;
  logic [5:0]  v;
  logic [15:0] unit;
  logic        unit_emit;
  logic [15:0] acc_step;

  assign sym = symbol_value(byte_in);
  assign v   = sym[5:0];

  // Six bits per symbol; the third, sixth and eighth symbol steps of each group of eight complete a 16-bit unit.
  always_comb begin
    unit      = 16'h0000;
    unit_emit = 1'b0;
    acc_step  = acc;
    case (phase)
      3'd0: acc_step = {v, 10'b0};
      3'd1: acc_step = acc + {6'b0, v, 4'b0};
      3'd2: begin
        unit      = acc + {12'b0, v[5:2]};
        unit_emit = 1'b1;
        acc_step  = {v[1:0], 14'b0};
      end
      3'd3: acc_step = acc + {2'b0, v, 8'b0};
      3'd4: acc_step = acc + {8'b0, v, 2'b0};
      3'd5: begin
        unit      = acc + {14'b0, v[5:4]};
        unit_emit = 1'b1;
        acc_step  = {v[3:0], 12'b0};
      end
      3'd6: acc_step = acc + {4'b0, v, 6'b0};
      3'd7: begin
        unit      = acc + {10'b0, v};
        unit_emit = 1'b1;
        acc_step  = 16'h0000;
      end
      default: acc_step = acc;
    endcase
  end

  // Mode handling and result selection.
  always_comb begin
    in_base64_next   = in_base64;
    fresh_next       = fresh;
    acc_next         = acc;
    phase_next       = phase;
    result.emit      = 1'b0;
    result.code_unit = 16'h0000;
    result.status    = STATUS_OK;
    if (!in_base64) begin
      if (byte_in == escape_byte) begin
        in_base64_next = 1'b1;
        fresh_next     = 1'b1;
        acc_next       = 16'h0000;
        phase_next     = 3'd0;
      end else begin
        result.emit      = 1'b1;
        result.code_unit = {8'h00, byte_in};
      end
    end else if (byte_in == DASH_BYTE) begin
      in_base64_next = 1'b0;
      if (fresh) begin
        fresh_next       = 1'b0;
        result.emit      = 1'b1;
        result.code_unit = {8'h00, escape_byte};
      end
    end else if (!sym[6]) begin
      // Illegal byte: report it and leave all state alone.
      result.emit   = 1'b1;
      result.status = STATUS_ILLEGAL;
    end else begin
      fresh_next       = 1'b0;
      acc_next         = acc_step;
      phase_next       = phase + 3'd1;
      result.emit      = unit_emit;
      result.code_unit = unit;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_byte <= ESCAPE_RESET;
    end else if (cfg_write) begin
      escape_byte <= cfg_data;
    end
  end

  // Decoder state advances once per byte taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_base64 <= 1'b0;
      fresh     <= 1'b0;
      acc       <= 16'h0000;
      phase     <= 3'd0;
    end else if (take) begin
      in_base64 <= in_base64_next;
      fresh     <= fresh_next;
      acc       <= acc_next;
      phase     <= phase_next;
    end
  end

endmodule

`default_nettype wire

### hdl/utf7d_out_stage.sv
// Result register that presents one decoded beat until the consumer takes it.
`default_nettype none

module utf7d_out_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire utf7d_pkg::utf7d_result_t result,
  output logic            can_take,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [15:0]     code_unit,
  output logic            status
);

  // The register is free when empty or emptied in this cycle.
  assign can_take = !out_valid || out_ready;

  // Valid flag follows whether the byte taken produced a result.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_take) begin
      out_valid <= take && result.emit;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (can_take && take) begin
      code_unit <= result.code_unit;
      status    <= result.status;
    end
  end

endmodule

`default_nettype wire

### hdl/utf7_byte_decoder.sv
// Top level of the UTF-7 byte decoder: input register, decode core and result register.
`default_nettype none

// Decodes one byte per beat into at most one 16-bit code unit. An accepted byte
// sits in the input register while the decode core works on it combinationally,
// and its result is loaded into the result register once that register is free,
// so a result passes through the input register and then the result register. A
// new byte is accepted every cycle while the result side keeps up; the mode and
// accumulator state in the decode core is the only data loop. The escape
// byte is written through cfg_write and cfg_data and should only change while no
// byte is in flight. Illegal bytes in base64 mode give a beat with status 1 and
// code_unit 0.
module utf7_byte_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      code_unit,
  output logic             status
);
  import utf7d_pkg::*;

  logic          held_valid;
  logic [7:0]    held_byte;
  logic          can_take;
  logic          take;
  utf7d_result_t result;

  // A held byte moves into the core when the result register is free.
  assign take = held_valid && can_take;

  utf7d_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .take       (take),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  utf7d_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .take      (take),
    .byte_in   (held_byte),
    .result    (result)
  );

  utf7d_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .result    (result),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .code_unit (code_unit),
    .status    (status)
  );

endmodule

`default_nettype wire

### hdl/utf7d_checker.sv
// Port-level checks for the UTF-7 byte decoder and their binding to the top level.
`default_nettype none

module utf7d_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] code_unit,
  input wire logic        status
);

  // An illegal-input beat carries a zero code unit.
  a_illegal_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> code_unit == 16'h0000)
    else $error("illegal-input beat with nonzero code unit");

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(code_unit) && $stable(status))
    else $error("result beat changed while stalled");

  // A new result beat must be preceded by an accepted byte.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result beat without a matching input beat");

  // With the result side empty the input side never stalls.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while result register empty");

endmodule

bind utf7_byte_decoder utf7d_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .code_unit (code_unit),
  .status    (status)
);

`default_nettype wire

### test/utf7_decode_checker.sv
// Scoreboard for the UTF-7 byte decoder: predicts code units from accepted bytes and checks them.
`timescale 1ns / 100ps

module utf7_decode_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] code_unit,
  input  logic        status,
  output int          fail_count,
  output int          pending,
  output int          beats_checked,
  output int          illegal_seen
);

  typedef struct packed {
    logic [15:0] code_unit;
    logic        status;
  } unit_beat_t;

  // Code units still owed by the block, oldest first.
  unit_beat_t expected_units[$];

  // Shadow of the escape register and of the decoder state.
  logic [7:0]  escape_q;
  logic        in_b64;
  logic        fresh;
  logic [15:0] acc_q;
  logic [2:0]  phase_q;

  // Value of a base64 symbol, or -1 for a byte outside the alphabet.
  function automatic int sextet_of(input logic [7:0] b);
    if (b >= 8'h41 && b <= 8'h5A) return int'(b - 8'h41);
    if (b >= 8'h61 && b <= 8'h7A) return int'(b - 8'h61) + 26;
    if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30) + 52;
    if (b == 8'h2B) return 62;
    if (b == 8'h2F) return 63;
    return -1;
  endfunction

  task automatic queue_unit(input logic [15:0] cu, input logic st);
    unit_beat_t beat;
    beat.code_unit = cu;
    beat.status = st;
    expected_units.push_back(beat);
  endtask

  // Advance the shadow decoder by one byte and queue the code unit it yields.
  task automatic predict_byte(input logic [7:0] b);
    int   sx;
    int   a;
    int   u;
    logic emit;
    sx = 0;
    a = int'(acc_q);
    u = 0;
    emit = 1'b0;
    if (!in_b64) begin
      if (b == escape_q) begin
        in_b64 = 1'b1;
        fresh = 1'b1;
        acc_q = 16'h0000;
        phase_q = 3'd0;
      end else begin
        queue_unit({8'h00, b}, utf7d_pkg::STATUS_OK);
      end
    end else if (b == utf7d_pkg::DASH_BYTE) begin
      // Leaving base64; a run with no symbols stands for the escape byte itself.
      in_b64 = 1'b0;
      if (fresh) begin
        fresh = 1'b0;
        queue_unit({8'h00, escape_q}, utf7d_pkg::STATUS_OK);
      end
    end else begin
      sx = sextet_of(b);
      if (sx < 0) begin
        // Illegal bytes report an error and leave every bit of state alone.
        queue_unit(16'h0000, utf7d_pkg::STATUS_ILLEGAL);
      end else begin
        fresh = 1'b0;
        // Eight symbols carry exactly three code units.
        case (phase_q)
          3'd0: a = sx << 10;
          3'd1: a = a + (sx << 4);
          3'd2: begin
            u = a + (sx >> 2);
            emit = 1'b1;
            a = (sx & 3) << 14;
          end
          3'd3: a = a + (sx << 8);
          3'd4: a = a + (sx << 2);
          3'd5: begin
            u = a + (sx >> 4);
            emit = 1'b1;
            a = (sx & 15) << 12;
          end
          3'd6: a = a + (sx << 6);
          default: begin
            u = a + sx;
            emit = 1'b1;
            a = 0;
          end
        endcase
        acc_q = a[15:0];
        phase_q = phase_q + 3'd1;
        if (emit) queue_unit(u[15:0], utf7d_pkg::STATUS_OK);
      end
    end
  endtask

  // Score result beats first, then predict from the input beat of the same edge.
  always @(posedge clk) begin : score
    unit_beat_t want;
    if (rst) begin
      expected_units.delete();
      escape_q = utf7d_pkg::ESCAPE_RESET;
      in_b64 = 1'b0;
      fresh = 1'b0;
      acc_q = 16'h0000;
      phase_q = 3'd0;
      fail_count = 0;
      beats_checked = 0;
      illegal_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        beats_checked++;
        if (expected_units.size() == 0) begin
          $error("result beat with nothing expected: code_unit %h status %b",
                 code_unit, status);
          fail_count++;
        end else begin
          want = expected_units.pop_front();
          if (code_unit !== want.code_unit) begin
            $error("code_unit mismatch: expected %h, got %h", want.code_unit, code_unit);
            fail_count++;
          end
          if (status !== want.status) begin
            $error("status mismatch: expected %b, got %b", want.status, status);
            fail_count++;
          end
          if (want.status == utf7d_pkg::STATUS_ILLEGAL) illegal_seen++;
        end
      end
      if (in_valid && in_ready) predict_byte(in_byte);
      if (cfg_write) escape_q = cfg_data;
    end
    pending = expected_units.size();
  end

endmodule

### test/testbench.sv
// Top of the UTF-7 byte decoder test: clock, reset, byte stimulus, escape settings and verdict.
`timescale 1ns / 100ps

module testbench;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int ITEMS_PER_PHASE = 310;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 8;
  localparam int NUM_PHASES      = 6;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [7:0]  cfg_data = 8'h00;
  logic        in_valid = 1'b0;
  logic [7:0]  in_byte = 8'h00;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [15:0] code_unit;
  logic        status;

  int fail_count;
  int pending;
  int beats_checked;
  int illegal_seen;

  int send_idle_pct = 22;
  int recv_idle_pct = 53;
  int hold_len = 0;
  int bytes_sent = 0;
  logic [7:0] escape_now = utf7d_pkg::ESCAPE_RESET;

  // Escape setting per phase; the first phase runs on the reset value.
  logic [7:0] escape_plan [NUM_PHASES] = '{8'h2B, 8'h00, 8'hFF, 8'h2D, 8'h41, 8'h2B};

  // Directed opening: direct extremes, escaped plus, a full symbol cycle, illegal bytes.
  logic [7:0] directed_bytes [$] = '{
    8'h00, 8'hFF, 8'h41, 8'h2D,
    8'h2B, 8'h2D,
    8'h2B, 8'h41, 8'h5A, 8'h61, 8'h7A, 8'h30, 8'h39, 8'h2B, 8'h2F,
    8'h2A, 8'hFF, 8'h2D,
    8'h2B, 8'h21, 8'h2D,
    8'h2B, 8'h42, 8'h2D
  };

  always #4 clk = ~clk;

  utf7_byte_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .code_unit (code_unit),
    .status    (status)
  );

  utf7_decode_checker u_decode_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .code_unit     (code_unit),
    .status        (status),
    .fail_count    (fail_count),
    .pending       (pending),
    .beats_checked (beats_checked),
    .illegal_seen  (illegal_seen)
  );

  // Offer one byte, with random idle cycles ahead of it, and hold it until accepted.
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] b64_char(input int v);
    if (v < 26) return 8'h41 + 8'(v);
    if (v < 52) return 8'h61 + 8'(v - 26);
    if (v < 62) return 8'h30 + 8'(v - 52);
    if (v == 62) return 8'h2B;
    return 8'h2F;
  endfunction

  // A byte that is neither a base64 symbol nor a dash.
  function automatic logic [7:0] stray_byte();
    case ($urandom_range(3))
      0: return 8'h80 | 8'($urandom_range(127));
      1: return 8'h2A;
      2: return 8'h20;
      default: return 8'h00;
    endcase
  endfunction

  task automatic push_base64_run(input int n, input logic close);
    push_byte(escape_now);
    repeat (n) begin
      if ($urandom_range(19) == 0) push_byte(stray_byte());
      else push_byte(b64_char($urandom_range(63)));
    end
    if (close) push_byte(utf7d_pkg::DASH_BYTE);
  endtask

  // Mostly well-formed base64 runs and direct text, with some raw noise.
  task automatic push_random_sequence();
    int pick;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 60) begin
      push_base64_run($urandom_range(24), $urandom_range(9) != 0);
    end else if (pick < 85) begin
      repeat ($urandom_range(1, 8)) begin
        b = 8'($urandom_range(255));
        if (b == escape_now) b = b ^ 8'h01;
        push_byte(b);
      end
    end else if (pick < 90) begin
      push_byte(escape_now);
      push_byte(utf7d_pkg::DASH_BYTE);
    end else begin
      repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(255)));
    end
  endtask

  // Drop valid and let every owed beat, and any byte with no result, drain.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_escape(input logic [7:0] v);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    escape_now = v;
  endtask

  // Receiver: random ready, or a long hold-off when the stimulus asks for one.
  initial begin : receiver
    int n;
    forever begin
      @(negedge clk);
      if (hold_len != 0) begin
        n = hold_len;
        hold_len = 0;
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Cycle counter that stops a hung run.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("watchdog: run exceeded %0d cycles", CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int goal;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // Idle pattern: sender light and receiver heavy, then swapped, then none.
      case (phase / 2)
        0: begin
          send_idle_pct = 22;
          recv_idle_pct = 53;
        end
        1: begin
          send_idle_pct = 53;
          recv_idle_pct = 22;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (phase == 0) begin
        foreach (directed_bytes[i]) push_byte(directed_bytes[i]);
      end else begin
        write_escape(escape_plan[phase]);
      end
      // Stall the result side long enough for the block to back up its input.
      if (phase == 4) hold_len = HOLD_CYCLES;
      goal = bytes_sent + ITEMS_PER_PHASE;
      while (bytes_sent < goal) push_random_sequence();
      wait_idle();
    end
    $display("Decoded %0d bytes under %0d escape settings, including 0x00, 0xFF and dash.",
             bytes_sent, NUM_PHASES);
    $display("Checked %0d result beats, %0d of them illegal-byte reports.",
             beats_checked, illegal_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/utf7d_pkg.sv
hdl/utf7d_in_stage.sv
hdl/utf7d_core.sv
hdl/utf7d_out_stage.sv
hdl/utf7_byte_decoder.sv
hdl/utf7d_checker.sv
test/utf7_decode_checker.sv
test/testbench.sv
